// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the core RTL.
// Both expect clk_i and rst_ni in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define PTSG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define PTSG_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// ----- rtl/core/ptsg_pkg.sv -----
`timescale 1ns / 1ps

package ptsg_pkg;

  localparam int unsigned FREQ_W    = 16;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned FUNC_W    = 3;
  localparam int unsigned RELOAD_W  = 20;
  localparam int unsigned COMPARE_W = 19;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned DIVD_W = 32;
  localparam int unsigned DIVS_W = 16;
  localparam int unsigned STEP_W = 5;

  localparam logic [DIVD_W-1:0] TIMER_HZ = 32'd1000000;

  localparam logic [FREQ_W-1:0] MIN_FREQ_RST = 16'd100;
  localparam logic [LEN_W-1:0]  DEF_LEN_RST  = 16'd80;

  // Command codes
  localparam logic [FUNC_W-1:0] FUNC_TICK     = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_BEEP     = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SWEEP    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_STOP     = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_BEEP_DEF = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FREQ = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_LEN  = 1'b1;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [FREQ_W-1:0] freq_a;
    logic [FREQ_W-1:0] freq_b;
    logic [LEN_W-1:0]  length_ms;
  } cmd_t;

  typedef struct packed {
    logic [RELOAD_W-1:0]  reload_value;
    logic [COMPARE_W-1:0] compare_value;
    logic                 tone_on;
    logic                 sweeping;
  } tone_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- rtl/core/ptsg_div.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Restoring divider, one quotient bit per cycle.
module ptsg_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ptsg_pkg::div_req_t  req_i,
  output ptsg_pkg::div_rsp_t  rsp_o
);

  logic                        busy_q;
  logic                        done_q;
  logic [ptsg_pkg::STEP_W-1:0] cnt_q;
  logic [ptsg_pkg::DIVD_W-1:0] quo_q;
  logic [ptsg_pkg::DIVS_W-1:0] rem_q;
  logic [ptsg_pkg::DIVS_W-1:0] dvs_q;

  logic [ptsg_pkg::DIVS_W:0]   trial;
  logic                        ge;
  logic [ptsg_pkg::DIVS_W-1:0] rem_d;

  assign trial = {rem_q, quo_q[ptsg_pkg::DIVD_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  // remainder stays below the divisor, so the low bits are enough
  assign rem_d = ge ? ptsg_pkg::DIVS_W'(trial - {1'b0, dvs_q})
                    : trial[ptsg_pkg::DIVS_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        quo_q  <= req_i.dividend;
        rem_q  <= '0;
        dvs_q  <= req_i.divisor;
      end else if (busy_q) begin
        quo_q <= {quo_q[ptsg_pkg::DIVD_W-2:0], ge};
        rem_q <= rem_d;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == ptsg_pkg::STEP_W'(ptsg_pkg::DIVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  `PTSG_NEVER(a_div_start_busy, req_i.start && busy_q, "divider restarted while busy")
  `PTSG_ASSERT(a_div_done_after_busy, done_q |-> !busy_q && $past(busy_q), "stray divider done")
  `PTSG_NEVER(a_div_done_start, done_q && req_i.start, "divider started on its done cycle")

endmodule

// ----- rtl/core/piezo_tone_sweep_generator_core.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Tone controller for a 1 MHz PWM timer. Every accepted command item returns one
// result item with the timer reload and compare values and the tone/sweep flags
// after the command. Stop, sweep start, ignored codes and ticks that leave the
// frequency alone go straight to the emit step; beeps make one pass through the
// shared 32-step divider (1000000/f) and sweep ticks two (one more for the sweep
// interpolation, ahead of 1000000/f). The next command can be accepted in the
// cycle its result comes out. in_stall_o stays high while a command is in work;
// the result register lets the next command start while a result is still
// waiting. The user must write configuration through cfg_we_i only while the
// block is idle; the block itself does not enforce it.
module piezo_tone_sweep_generator_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ptsg_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ptsg_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  ptsg_pkg::cmd_t                     in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output ptsg_pkg::tone_t                    out_data_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_DIV1S = 3'd2;
  localparam logic [2:0] S_DIV1W = 3'd3;
  localparam logic [2:0] S_DIV2S = 3'd4;
  localparam logic [2:0] S_DIV2W = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0] state_q;

  logic [ptsg_pkg::FREQ_W-1:0]    min_q;
  logic [ptsg_pkg::LEN_W-1:0]     def_q;
  logic [ptsg_pkg::LEN_W-1:0]     elapsed_q;
  logic [ptsg_pkg::LEN_W-1:0]     length_q;
  logic [ptsg_pkg::FREQ_W-1:0]    from_q;
  logic [ptsg_pkg::FREQ_W-1:0]    to_q;
  logic                           running_q;
  logic                           sweep_q;
  logic [ptsg_pkg::RELOAD_W-1:0]  reload_q;
  logic [ptsg_pkg::COMPARE_W-1:0] compare_q;
  logic [ptsg_pkg::FREQ_W-1:0]    freq_q;
  logic [ptsg_pkg::DIVD_W-1:0]    prod_q;
  logic                           out_valid_q;
  ptsg_pkg::tone_t                out_q;

  ptsg_pkg::div_req_t div_req;
  ptsg_pkg::div_rsp_t div_rsp;

  logic                          accept;
  logic [ptsg_pkg::LEN_W-1:0]    elapsed_d;
  logic                          down;
  logic [ptsg_pkg::FREQ_W-1:0]   span;
  logic [ptsg_pkg::FREQ_W-1:0]   step;
  logic [ptsg_pkg::FREQ_W-1:0]   fsum;
  logic [ptsg_pkg::FREQ_W-1:0]   ffloor;
  logic [ptsg_pkg::RELOAD_W-1:0] period;
  logic                          out_free;
  logic                          emit;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = (state_q == S_EMIT) && out_free;

  assign elapsed_d = (elapsed_q != '1) ? elapsed_q + 1'b1 : elapsed_q;

  // |to - from| and direction of the sweep
  assign down = to_q < from_q;
  assign span = down ? from_q - to_q : to_q - from_q;

  // quotient is below span, so the sum stays within 0..65535
  assign step   = div_rsp.quotient[ptsg_pkg::FREQ_W-1:0];
  assign fsum   = down ? from_q - step : from_q + step;
  assign ffloor = (fsum < min_q) ? min_q : fsum;
  assign period = div_rsp.quotient[ptsg_pkg::RELOAD_W-1:0];

  always_comb begin
    div_req = '0;
    unique case (state_q)
      S_DIV1S: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_q;
        div_req.divisor  = length_q;
      end
      S_DIV2S: begin
        div_req.start    = 1'b1;
        div_req.dividend = ptsg_pkg::TIMER_HZ;
        div_req.divisor  = freq_q;
      end
      default: ;
    endcase
  end

  ptsg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= ptsg_pkg::MIN_FREQ_RST;
      def_q <= ptsg_pkg::DEF_LEN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ptsg_pkg::CFG_MIN_FREQ: min_q <= cfg_wdata_i;
        ptsg_pkg::CFG_DEF_LEN:  def_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      elapsed_q   <= '0;
      length_q    <= '0;
      from_q      <= '0;
      to_q        <= '0;
      running_q   <= 1'b0;
      sweep_q     <= 1'b0;
      reload_q    <= '0;
      compare_q   <= '0;
      freq_q      <= '0;
      prod_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      out_valid_q <= emit || (out_valid_q && out_stall_i);
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_EMIT;
            case (in_data_i.func) inside
              ptsg_pkg::FUNC_TICK: begin
                if (running_q) begin
                  elapsed_q <= elapsed_d;
                  if (elapsed_d >= length_q) begin
                    compare_q <= '0;
                    running_q <= 1'b0;
                    sweep_q   <= 1'b0;
                  end else if (sweep_q) begin
                    state_q <= S_MUL;
                  end
                end
              end
              ptsg_pkg::FUNC_BEEP, ptsg_pkg::FUNC_BEEP_DEF: begin
                freq_q    <= (in_data_i.freq_a == '0) ? ptsg_pkg::FREQ_W'(1)
                                                      : in_data_i.freq_a;
                length_q  <= (in_data_i.func == ptsg_pkg::FUNC_BEEP) ? in_data_i.length_ms
                                                                      : def_q;
                elapsed_q <= '0;
                running_q <= 1'b1;
                sweep_q   <= 1'b0;
                state_q   <= S_DIV2S;
              end
              ptsg_pkg::FUNC_SWEEP: begin
                from_q    <= in_data_i.freq_a;
                to_q      <= in_data_i.freq_b;
                length_q  <= in_data_i.length_ms;
                elapsed_q <= '0;
                running_q <= 1'b1;
                sweep_q   <= 1'b1;
              end
              ptsg_pkg::FUNC_STOP: begin
                compare_q <= '0;
                running_q <= 1'b0;
                sweep_q   <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_MUL: begin
          prod_q  <= ptsg_pkg::DIVD_W'(span) * ptsg_pkg::DIVD_W'(elapsed_q);
          state_q <= S_DIV1S;
        end
        S_DIV1S: state_q <= S_DIV1W;
        S_DIV1W: begin
          if (div_rsp.done) begin
            freq_q  <= (ffloor == '0) ? ptsg_pkg::FREQ_W'(1) : ffloor;
            state_q <= S_DIV2S;
          end
        end
        S_DIV2S: state_q <= S_DIV2W;
        S_DIV2W: begin
          if (div_rsp.done) begin
            reload_q  <= period - 1'b1;
            compare_q <= period[ptsg_pkg::RELOAD_W-1:1];
            state_q   <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_q.reload_value  <= reload_q;
            out_q.compare_value <= compare_q;
            out_q.tone_on       <= running_q;
            out_q.sweeping      <= sweep_q;
            state_q             <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `PTSG_ASSERT(a_sweep_needs_tone, sweep_q |-> running_q, "sweep flag without running tone")
  `PTSG_ASSERT(a_silent_compare, (compare_q != '0) |-> running_q, "compare set while silent")
  `PTSG_ASSERT(a_div_only_in_div, div_rsp.done |-> (state_q == S_DIV1W || state_q == S_DIV2W),
               "divider result outside a wait state")

endmodule
